// ===== hw/rtl/nwcs_pkg.sv =====
package nwcs_pkg;

	localparam int GRID_SIZE  = 64;
	localparam int MAX_RADIUS = 8;

	localparam int COORD_W  = $clog2(GRID_SIZE);
	localparam int ADDR_W   = 2 * COORD_W;
	localparam int DIM_W    = 7;
	localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
	localparam int OFS_W    = RAD_W + 1;
	localparam int CAND_W   = COORD_W + 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic               walkable_bit;
	} req_t;

	typedef struct packed {
		logic [5:0] found_x;
		logic [5:0] found_y;
		logic       found;
	} resp_t;

endpackage

// ===== hw/rtl/nearest_walkable_cell_search_unit.sv =====
// Nearest walkable cell search over a 64 x 64 one-bit walkability map.
// Input channel (in_valid/in_ready, in_item): a write transaction stores one
// map bit (ignored outside the map) and returns nothing; a query transaction
// clamps its seed into the configured width and height, tests the seed and
// then the square rings of radius 1 to 8, row by row, and returns one
// result on the output channel (out_valid/out_ready, out_item).
// Configuration (cfg_we, cfg_index, cfg_wdata) sets grid width and height;
// write it only while the block is idle.
// A query visits one cell per cycle, the seed first, up to and including
// the hit: a map read is issued on the single read port for each visited
// cell inside the grid and its data is checked the next cycle. The input
// is not ready during a query.
// After reset the map is swept to not walkable, one cell per cycle; no
// transaction is accepted during the sweep, and configuration returns to
// 64 x 64. A result waits in the output register while out_ready is low; a
// further query may start meanwhile and holds its result until the register
// frees up.
module nearest_walkable_cell_search_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  nwcs_pkg::req_t                   in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output nwcs_pkg::resp_t                  out_item,
	input  logic                             cfg_we,
	input  logic [nwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nwcs_pkg::DIM_W-1:0]       cfg_wdata
);
	import nwcs_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [DIM_W-1:0]        width_q, height_q;
	logic [ADDR_W-1:0]       clr_addr_q;
	logic [COORD_W-1:0]      sx_q, sy_q;
	logic [RAD_W-1:0]        r_q;
	logic signed [OFS_W-1:0] dx_q, dy_q;
	logic                    pend_q;
	logic [COORD_W-1:0]      pend_x_q, pend_y_q;
	logic                    rd_data_q;
	resp_t                   res_q;
	logic                    out_valid_q;
	resp_t                   out_item_q;

	logic                    mem [GRID_SIZE*GRID_SIZE];

	logic [DIM_W-1:0]        w_eff, h_eff, w_max, h_max;
	logic [COORD_W-1:0]      seed_x, seed_y;
	logic signed [CAND_W-1:0] cx, cy;
	logic                    cand_inb;
	logic signed [OFS_W-1:0] r_s;
	logic                    last_cand;
	logic [RAD_W-1:0]        r_n;
	logic signed [OFS_W-1:0] dx_n, dy_n;
	logic                    accept, wr_inb;
	logic                    mem_we, mem_wd, mem_re;
	logic [ADDR_W-1:0]       mem_wa, mem_ra;
	logic                    hit, load_out;

	always_comb begin
		w_eff = (width_q == '0) ? DIM_W'(1) :
			(width_q > DIM_W'(GRID_SIZE)) ? DIM_W'(GRID_SIZE) : width_q;
		h_eff = (height_q == '0) ? DIM_W'(1) :
			(height_q > DIM_W'(GRID_SIZE)) ? DIM_W'(GRID_SIZE) : height_q;
		w_max = w_eff - DIM_W'(1);
		h_max = h_eff - DIM_W'(1);
		if (in_item.cell_x[15]) begin
			seed_x = '0;
		end else if ($unsigned(in_item.cell_x) > 16'(w_max)) begin
			seed_x = w_max[COORD_W-1:0];
		end else begin
			seed_x = in_item.cell_x[COORD_W-1:0];
		end
		if (in_item.cell_y[15]) begin
			seed_y = '0;
		end else if ($unsigned(in_item.cell_y) > 16'(h_max)) begin
			seed_y = h_max[COORD_W-1:0];
		end else begin
			seed_y = in_item.cell_y[COORD_W-1:0];
		end
	end

	always_comb begin
		r_s = $signed({1'b0, r_q});
		cx = $signed({2'b00, sx_q}) + CAND_W'(dx_q);
		cy = $signed({2'b00, sy_q}) + CAND_W'(dy_q);
		cand_inb = !cx[CAND_W-1] && !cy[CAND_W-1]
			&& ($unsigned(cx) < CAND_W'(w_eff)) && ($unsigned(cy) < CAND_W'(h_eff));
		last_cand = (r_q == RAD_W'(MAX_RADIUS)) && (dx_q == r_s) && (dy_q == r_s);
		r_n = r_q;
		dx_n = dx_q;
		dy_n = dy_q;
		if (dx_q == r_s) begin
			if (dy_q == r_s) begin
				r_n = r_q + RAD_W'(1);
				dy_n = -(r_s + OFS_W'(1));
				dx_n = -(r_s + OFS_W'(1));
			end else begin
				dy_n = dy_q + OFS_W'(1);
				dx_n = -r_s;
			end
		end else if (dy_q != r_s && dy_q != -r_s) begin
			dx_n = r_s;
		end else begin
			dx_n = dx_q + OFS_W'(1);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_inb   = !in_item.cell_x[15] && !in_item.cell_y[15]
		&& ($unsigned(in_item.cell_x) < 16'(GRID_SIZE))
		&& ($unsigned(in_item.cell_y) < 16'(GRID_SIZE));
	assign hit      = pend_q && rd_data_q;
	assign load_out = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && in_item.req_type == REQ_WRITE && wr_inb) begin
			mem_we = 1'b1;
			mem_wa = {in_item.cell_y[COORD_W-1:0], in_item.cell_x[COORD_W-1:0]};
			mem_wd = in_item.walkable_bit;
		end
		mem_re = (state_q == ST_SCAN) && cand_inb;
		mem_ra = {cy[COORD_W-1:0], cx[COORD_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(GRID_SIZE);
			height_q <= DIM_W'(GRID_SIZE);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  width_q  <= cfg_wdata;
				CFG_GRID_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_item.req_type == REQ_QUERY) begin
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						pend_q  <= 1'b0;
						state_q <= ST_RESULT;
					end else begin
						pend_q <= cand_inb;
						if (last_cand) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= seed_x;
			sy_q <= seed_y;
			r_q  <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end else if (state_q == ST_SCAN) begin
			r_q  <= r_n;
			dx_q <= dx_n;
			dy_q <= dy_n;
			pend_x_q <= cx[COORD_W-1:0];
			pend_y_q <= cy[COORD_W-1:0];
		end
		if (((state_q == ST_SCAN) || (state_q == ST_DRAIN)) && hit) begin
			res_q.found_x <= pend_x_q;
			res_q.found_y <= pend_y_q;
			res_q.found   <= 1'b1;
		end else if (state_q == ST_DRAIN) begin
			res_q.found_x <= sx_q;
			res_q.found_y <= sy_q;
			res_q.found   <= 1'b0;
		end
		if (load_out) begin
			out_item_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_radius_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (r_q <= RAD_W'(MAX_RADIUS)))
		else $error("ring radius past limit");

	a_seed_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((DIM_W'(sx_q) < w_eff) && (DIM_W'(sy_q) < h_eff)))
		else $error("seed outside configured grid");

	a_pend_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ((DIM_W'(pend_x_q) < w_eff) && (DIM_W'(pend_y_q) < h_eff)))
		else $error("map read outside configured grid");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("map clear restarted");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("stale map read pending in idle");

endmodule

// ===== verif/nearest_walkable_cell_search_unit_test.sv =====
module nearest_walkable_cell_search_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nwcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS = 100;
	localparam int LONG_HOLD = 700;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		req_t  item;
		logic  typed;
		resp_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{REQ_QUERY, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sh8000, 16'sh8000, 1'b0}, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sh7fff, 16'sh7fff, 1'b1}, 1'b1, '{6'd63, 6'd63, 1'b0}},
		'{'{REQ_QUERY, 16'sh7fff, 16'sh8000, 1'b0}, 1'b1, '{6'd63, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd64, 16'sd0, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd0, 16'sd64, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, -16'sd1, 16'sd3, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd3, -16'sd1, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sh7fff, 16'sh8000, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd0, 16'sd0, 1'b0}, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd63, 16'sd3, 1'b1}, 1'b1, '{6'd63, 6'd3, 1'b0}},
		'{'{REQ_WRITE, 16'sd0, 16'sd0, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, -16'sd7, -16'sd9, 1'b0}, 1'b1, '{6'd0, 6'd0, 1'b1}},
		'{'{REQ_WRITE, 16'sd0, 16'sd0, 1'b0}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd5, 16'sd5, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd8, 16'sd8, 1'b0}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd13, 16'sd13, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd14, 16'sd14, 1'b0}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd5, 16'sd5, 1'b0}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd6, 16'sd4, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd4, 16'sd6, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sd5, 16'sd5, 1'b0}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_WRITE, 16'sd63, 16'sd63, 1'b1}, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{'{REQ_QUERY, 16'sh7fff, 16'sh7fff, 1'b0}, 1'b1, '{6'd63, 6'd63, 1'b1}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	req_t                 in_item;
	logic                 out_valid;
	logic                 out_ready;
	resp_t                out_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;

	resp_t            expected_cells[$];
	logic             walk_map [GRID_SIZE*GRID_SIZE];
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;
	int               error_count = 0;
	int               quiet_cycles = 0;
	int               burst_left;
	bit               offering;

	nearest_walkable_cell_search_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic resp_t nearest_cell(input int qx, input int qy);
		int    w, h, sx, sy, rx, ry, r, dx, dy, cx, cy, ax, ay;
		logic  hit;
		resp_t res;
		w = (cur_width == '0) ? 1 : (int'(cur_width) > GRID_SIZE) ? GRID_SIZE : int'(cur_width);
		h = (cur_height == '0) ? 1 : (int'(cur_height) > GRID_SIZE) ? GRID_SIZE : int'(cur_height);
		sx = (qx < 0) ? 0 : (qx > w - 1) ? w - 1 : qx;
		sy = (qy < 0) ? 0 : (qy > h - 1) ? h - 1 : qy;
		rx = sx;
		ry = sy;
		hit = walk_map[sy * GRID_SIZE + sx];
		for (r = 1; r <= MAX_RADIUS && !hit; r++) begin
			for (dy = -r; dy <= r && !hit; dy++) begin
				for (dx = -r; dx <= r && !hit; dx++) begin
					cx = sx + dx;
					cy = sy + dy;
					ax = (dx < 0) ? -dx : dx;
					ay = (dy < 0) ? -dy : dy;
					if (((ax > ay) ? ax : ay) == r && cx >= 0 && cy >= 0 && cx < w && cy < h) begin
						if (walk_map[cy * GRID_SIZE + cx]) begin
							rx = cx;
							ry = cy;
							hit = 1'b1;
						end
					end
				end
			end
		end
		res.found_x = 6'(rx);
		res.found_y = 6'(ry);
		res.found = hit;
		return res;
	endfunction

	task automatic wait_for_results();
		while (expected_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer(input req_t item, input bit typed, input resp_t want);
		int wx, wy;
		in_item <= item;
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		wx = $signed(item.cell_x);
		wy = $signed(item.cell_y);
		if (item.req_type == REQ_WRITE) begin
			if (wx >= 0 && wy >= 0 && wx < GRID_SIZE && wy < GRID_SIZE)
				walk_map[wy * GRID_SIZE + wx] = item.walkable_bit;
		end else begin
			expected_cells.push_back(typed ? want : nearest_cell(wx, wy));
		end
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end else if ($urandom_range(0, 149) == 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			wait_for_results();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GRID_WIDTH: cur_width = data;
			CFG_GRID_HEIGHT: cur_height = data;
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		wait_for_results();
		write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, 7'($urandom));
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_HEIGHT, h);
	endtask

	initial begin
		int   phase, hx, hy, spread;
		req_t item;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_wdata <= '0;
		foreach (walk_map[i]) walk_map[i] = 1'b0;
		cur_width = DIM_W'(GRID_SIZE);
		cur_height = DIM_W'(GRID_SIZE);
		offering = 1'b0;
		burst_left = $urandom_range(1, 30);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) offer(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_grid(7'd0, 7'd0);
				1: set_grid(7'd127, 7'd127);
				2: set_grid(7'd1, 7'd64);
				3: set_grid(7'd64, 7'd1);
				4: set_grid(7'd64, 7'd64);
				default: set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
			endcase
			hx = $urandom_range(0, GRID_SIZE - 1);
			hy = $urandom_range(0, GRID_SIZE - 1);
			repeat (PHASE_ITEMS) begin
				item.req_type = ($urandom_range(0, 9) < 6) ? REQ_WRITE : REQ_QUERY;
				if ($urandom_range(0, 6) == 0) begin
					item.cell_x = 16'($urandom);
					item.cell_y = 16'($urandom);
				end else begin
					spread = (item.req_type == REQ_WRITE) ? 10 : 14;
					item.cell_x = 16'(hx + int'($urandom_range(0, 2 * spread)) - spread);
					item.cell_y = 16'(hy + int'($urandom_range(0, 2 * spread)) - spread);
				end
				if (item.req_type == REQ_WRITE)
					item.walkable_bit = ($urandom_range(0, 3) == 0);
				else
					item.walkable_bit = 1'($urandom);
				offer(item, 1'b0, '0);
			end
		end

		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int    hold_left, mode, mode_left, results_seen;
		resp_t want;
		out_ready <= 1'b0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected result: found_x %0d found_y %0d found %0d",
						out_item.found_x, out_item.found_y, out_item.found);
					error_count++;
				end else begin
					want = expected_cells.pop_front();
					if (out_item.found_x !== want.found_x) begin
						$error("found_x: expected %0d, actual %0d", want.found_x, out_item.found_x);
						error_count++;
					end
					if (out_item.found_y !== want.found_y) begin
						$error("found_y: expected %0d, actual %0d", want.found_y, out_item.found_y);
						error_count++;
					end
					if (out_item.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, out_item.found);
						error_count++;
					end
				end
				results_seen++;
				if (results_seen == 40 || results_seen == 200)
					hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
